FILE: hdl/mrtq_pkg.sv
// mrtq_pkg: shared constants and types for the multi-ring task queue engine
// no dependencies
`timescale 1ns / 1ps
package mrtq_pkg;
  localparam int unsigned RingDepth = 64;
  localparam int unsigned MaxRings  = 8;
  localparam int unsigned WaitDepth = 64;
  localparam int unsigned TaskBits  = 16;

  localparam logic [2:0] ActReset  = 3'd0;
  localparam logic [2:0] ActSubRr  = 3'd1;
  localparam logic [2:0] ActSubTo  = 3'd2;
  localparam logic [2:0] ActPop    = 3'd3;
  localparam logic [2:0] ActPark   = 3'd4;
  localparam logic [2:0] ActWake   = 3'd5;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StBad   = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  localparam logic [0:0] RegWorkers = 1'd0;
  localparam logic [0:0] RegParkAll = 1'd1;
endpackage

FILE: hdl/mrtq_if.sv
// mrtq_req_if / mrtq_rsp_if: valid-ready channels for requests and results
// depends on nothing but the widths handed in
`timescale 1ns / 1ps
interface mrtq_req_if #(parameter int unsigned TB = 16);
  logic          valid;
  logic          ready;
  logic [2:0]    action;
  logic [2:0]    worker;
  logic [TB-1:0] task_id;
  logic          io_suspend;
  logic [6:0]    wake_limit;
  modport source (output valid, action, worker, task_id, io_suspend, wake_limit, input ready);
  modport sink   (input valid, action, worker, task_id, io_suspend, wake_limit, output ready);
endinterface

interface mrtq_rsp_if #(parameter int unsigned TB = 16);
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [TB-1:0] popped_task;
  logic [6:0]    moved;
  logic [5:0]    worker_pending;
  logic [8:0]    total_pending;
  logic [6:0]    waiting;
  modport source (output valid, status, popped_task, moved, worker_pending, total_pending,
                  waiting, input ready);
  modport sink   (input valid, status, popped_task, moved, worker_pending, total_pending,
                  waiting, output ready);
endinterface

FILE: hdl/multi_ring_task_queue_engine.sv
// multi_ring_task_queue_engine: top level, ring and wait-stack memories with sequencer
// depends on mrtq_pkg and the channel interfaces in mrtq_if.sv
//
//  channel | dir | content
//  req     | in  | action, worker, task_id, io_suspend, wake_limit
//  rsp     | out | status, popped_task, moved, worker_pending, total_pending, waiting
//  apb     | in  | workers_in_use (0x0), park_all_to_wait (0x4)
//
// submits, park, reset and unknown actions go through S_EXEC and S_DONE, pop also S_POPRD;
// a wake goes through S_EXEC, S_WAKERD and S_WAKEWR for each waiter moved and ends when a
// submit fails, as the wait stack is read one entry at a time.
// occupancies live in registers, so the totals need no memory reads.
// one request at a time; a result held by a stalled sink holds the next one in its last
// cycle until the output register is free.
`timescale 1ns / 1ps
module multi_ring_task_queue_engine #(
  parameter int unsigned RING_DEPTH = mrtq_pkg::RingDepth,
  parameter int unsigned MAX_RINGS  = mrtq_pkg::MaxRings,
  parameter int unsigned WAIT_DEPTH = mrtq_pkg::WaitDepth,
  parameter int unsigned TASK_BITS  = mrtq_pkg::TaskBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  mrtq_req_if.sink    req,
  mrtq_rsp_if.source  rsp
);
  localparam int unsigned RB = $clog2(RING_DEPTH);
  localparam int unsigned WB = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
  localparam int unsigned SB = $clog2(WAIT_DEPTH);
  localparam int unsigned CB = SB + 1;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_POPRD, S_WAKERD, S_WAKEWR, S_DONE} state_e;

  logic [TASK_BITS-1:0] ring_mem [MAX_RINGS*RING_DEPTH];
  logic [TASK_BITS-1:0] wait_mem [WAIT_DEPTH];
  logic [RB-1:0] head_q [MAX_RINGS];
  logic [RB-1:0] tail_q [MAX_RINGS];
  logic [CB-1:0] wcnt_q;
  logic [31:0]   rr_q;
  logic [WB-1:0] rmod_q [MAX_RINGS];
  logic [3:0]    wiu_q;
  logic          pall_q;

  state_e state_q;
  logic [2:0]    act_q;
  logic [2:0]    wk_q;
  logic [TASK_BITS-1:0] tid_q;
  logic          io_q;
  logic [6:0]    lim_q;
  logic [1:0]    st_q;
  logic [TASK_BITS-1:0] pop_q;
  logic [6:0]    mov_q;
  logic [3:0]    addr_q;
  logic          rsp_v_q;
  logic [TASK_BITS-1:0] rd_ring_q, rd_wait_q;

  // result register
  logic [1:0]           o_st_q;
  logic [TASK_BITS-1:0] o_pop_q;
  logic [6:0]           o_mov_q;
  logic [5:0]           o_wp_q;
  logic [8:0]           o_tot_q;
  logic [6:0]           o_wait_q;
  logic                 done_fire;

  // ring and wait memory ports
  logic                 rw_en, rr_en;
  logic [WB+RB-1:0]     rw_a, rr_a;
  logic [TASK_BITS-1:0] rw_d;
  logic                 ww_en, wr_en;
  logic [SB-1:0]        ww_a, wr_a;

  always_ff @(posedge clk_i) begin
    if (rw_en) ring_mem[rw_a] <= rw_d;
    if (rr_en) rd_ring_q <= ring_mem[rr_a];
    if (ww_en) wait_mem[ww_a] <= tid_q;
    if (wr_en) rd_wait_q <= wait_mem[wr_a];
  end

  // active rings
  logic [4:0] n_act;
  always_comb begin
    if (wiu_q == 4'd0) n_act = 5'd1;
    else if (32'(wiu_q) > MAX_RINGS) n_act = 5'(MAX_RINGS);
    else n_act = {1'b0, wiu_q};
  end

  function automatic logic [RB:0] occ(input logic [RB-1:0] h, input logic [RB-1:0] t);
    logic [RB:0] d;
    d = {1'b0, t} - {1'b0, h};
    if (t < h) d = d + (RB+1)'(RING_DEPTH);
    return d;
  endfunction

  logic [RB:0] occ_v [MAX_RINGS];
  logic [9:0]  total;
  always_comb begin
    total = '0;
    for (int i = 0; i < MAX_RINGS; i++) begin
      occ_v[i] = occ(head_q[i], tail_q[i]);
      if (5'(i) < n_act) total = total + 10'(occ_v[i]);
    end
  end

  // round-robin pick: counter residue kept for every ring count
  logic       rr_step;
  logic [3:0] rr_pick;
  assign rr_step = (state_q == S_EXEC && act_q == mrtq_pkg::ActSubRr) || state_q == S_WAKEWR;
  assign rr_pick = 4'(rmod_q[WB'(n_act - 5'd1)]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_RINGS; k++) rmod_q[k] <= '0;
    end else if (rr_step) begin
      for (int k = 0; k < MAX_RINGS; k++) begin
        if (rr_q == '1 || 32'(rmod_q[k]) == 32'(k)) rmod_q[k] <= '0;
        else rmod_q[k] <= rmod_q[k] + WB'(1);
      end
    end
  end

  // ring target and push check
  logic [3:0]  tgt;
  logic        tgt_ok, tgt_full;
  logic [WB-1:0] tgt_i;
  assign tgt      = (act_q == mrtq_pkg::ActSubRr || state_q == S_WAKEWR) ? rr_pick : {1'b0, wk_q};
  assign tgt_ok   = {1'b0, tgt} < n_act;
  assign tgt_i    = WB'(tgt);
  assign tgt_full = occ_v[tgt_i] >= (RB+1)'(RING_DEPTH - 1);

  always_comb begin
    rw_en = 1'b0; rw_a = {tgt_i, tail_q[tgt_i]};
    rw_d  = (state_q == S_WAKEWR) ? rd_wait_q : tid_q;
    rr_en = (state_q == S_EXEC) && act_q == mrtq_pkg::ActPop;
    rr_a  = {WB'(wk_q), head_q[WB'(wk_q)]};
    ww_en = 1'b0; ww_a = SB'(wcnt_q);
    wr_en = (state_q == S_EXEC) && act_q == mrtq_pkg::ActWake && wcnt_q != '0;
    wr_a  = SB'(wcnt_q - CB'(1));
    if (state_q == S_EXEC) begin
      if ((act_q == mrtq_pkg::ActSubRr || act_q == mrtq_pkg::ActSubTo ||
           (act_q == mrtq_pkg::ActPark && !io_q && !pall_q)) &&
          tid_q != '0 && tgt_ok && !tgt_full)
        rw_en = 1'b1;
      if (act_q == mrtq_pkg::ActPark && tid_q != '0 && (io_q || pall_q) &&
          32'(wcnt_q) < WAIT_DEPTH)
        ww_en = 1'b1;
    end
    if (state_q == S_WAKEWR && rd_wait_q != '0 && tgt_ok && !tgt_full) rw_en = 1'b1;
  end

  // a zero limit moves waiters until the stack is empty or a submit fails
  logic wake_more;
  assign wake_more = (lim_q == '0) || (mov_q < lim_q);

  assign req.ready = (state_q == S_IDLE);
  assign done_fire = (state_q == S_DONE) && (!rsp_v_q || rsp.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; rsp_v_q <= 1'b0; wcnt_q <= '0; rr_q <= '0;
      wiu_q <= 4'd1; pall_q <= 1'b0;
      for (int i = 0; i < MAX_RINGS; i++) begin head_q[i] <= '0; tail_q[i] <= '0; end
      act_q <= '0; wk_q <= '0; tid_q <= '0; io_q <= 1'b0; lim_q <= '0;
      st_q <= '0; pop_q <= '0; mov_q <= '0; addr_q <= '0;
      o_st_q <= '0; o_pop_q <= '0; o_mov_q <= '0; o_wp_q <= '0; o_tot_q <= '0;
      o_wait_q <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == mrtq_pkg::RegWorkers) wiu_q <= pwdata[3:0];
        else pall_q <= pwdata[0];
      end
      if (done_fire) rsp_v_q <= 1'b1;
      else if (rsp.ready) rsp_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            act_q <= req.action; wk_q <= req.worker; tid_q <= req.task_id;
            io_q <= req.io_suspend; lim_q <= req.wake_limit;
            st_q <= mrtq_pkg::StOk; pop_q <= '0; mov_q <= '0;
            addr_q <= {1'b0, req.worker};
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (act_q)
            mrtq_pkg::ActReset: begin
              for (int i = 0; i < MAX_RINGS; i++)
                if (5'(i) < n_act) begin head_q[i] <= '0; tail_q[i] <= '0; end
              wcnt_q <= '0;
              state_q <= S_DONE;
            end
            mrtq_pkg::ActSubRr, mrtq_pkg::ActSubTo: begin
              if (act_q == mrtq_pkg::ActSubRr) begin
                rr_q <= rr_q + 32'd1; addr_q <= rr_pick;
              end
              if (tid_q == '0 || !tgt_ok) st_q <= mrtq_pkg::StBad;
              else if (tgt_full) st_q <= mrtq_pkg::StFull;
              else tail_q[tgt_i] <= tail_q[tgt_i] + RB'(1);
              state_q <= S_DONE;
            end
            mrtq_pkg::ActPop: begin
              if (!tgt_ok) begin
                st_q <= mrtq_pkg::StBad; state_q <= S_DONE;
              end else if (occ_v[tgt_i] == '0) begin
                st_q <= mrtq_pkg::StEmpty; state_q <= S_DONE;
              end else begin
                head_q[tgt_i] <= head_q[tgt_i] + RB'(1);
                state_q <= S_POPRD;
              end
            end
            mrtq_pkg::ActPark: begin
              if (tid_q == '0) st_q <= mrtq_pkg::StBad;
              else if (io_q || pall_q) begin
                if (32'(wcnt_q) >= WAIT_DEPTH) st_q <= mrtq_pkg::StFull;
                else wcnt_q <= wcnt_q + CB'(1);
              end else if (!tgt_ok) st_q <= mrtq_pkg::StBad;
              else if (tgt_full) st_q <= mrtq_pkg::StFull;
              else tail_q[tgt_i] <= tail_q[tgt_i] + RB'(1);
              state_q <= S_DONE;
            end
            mrtq_pkg::ActWake: begin
              if (wcnt_q != '0 && wake_more) state_q <= S_WAKERD;
              else state_q <= S_DONE;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_POPRD: begin
          pop_q <= rd_ring_q; state_q <= S_DONE;
        end
        S_WAKERD: state_q <= S_WAKEWR;
        S_WAKEWR: begin
          rr_q <= rr_q + 32'd1;
          if (rd_wait_q == '0 || !tgt_ok || tgt_full) begin
            st_q <= mrtq_pkg::StFull; state_q <= S_DONE;
          end else begin
            tail_q[tgt_i] <= tail_q[tgt_i] + RB'(1);
            wcnt_q <= wcnt_q - CB'(1);
            mov_q <= mov_q + 7'd1;
            state_q <= S_EXEC;
          end
        end
        S_DONE: begin
          if (done_fire) begin
            o_st_q   <= st_q;
            o_pop_q  <= pop_q;
            o_mov_q  <= mov_q;
            o_wp_q   <= ({1'b0, addr_q} < n_act) ? 6'(occ_v[WB'(addr_q)]) : 6'd0;
            o_tot_q  <= 9'(total);
            o_wait_q <= 7'(wcnt_q);
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid          = rsp_v_q;
  assign rsp.status         = o_st_q;
  assign rsp.popped_task    = o_pop_q;
  assign rsp.moved          = o_mov_q;
  assign rsp.worker_pending = o_wp_q;
  assign rsp.total_pending  = o_tot_q;
  assign rsp.waiting        = o_wait_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mrtq_pkg::RegWorkers) ? {28'd0, wiu_q} : {31'd0, pall_q};

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !req.ready) else $error("ready while busy");
  a_wcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wcnt_q) <= WAIT_DEPTH) else $error("wait count overflow");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> rsp_v_q) else $error("result not raised");
endmodule
